/* rtl/ppm_ascii_pixel_encoder_top_defines.svh */
// Assertion macros for the PPM text encoder.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PPM_ASCII_PIXEL_ENCODER_TOP_DEFINES_SVH
`define PPM_ASCII_PIXEL_ENCODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPE_ASSERT(lbl, prop, msg)
`define PPE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/ppe_pkg.sv */
// Shared constants, item type and helper functions of the PPM text encoder.
// No dependencies.
package ppe_pkg;

  localparam int DIM_BITS   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int LEVEL_W    = 16;
  localparam int LINE_LIMIT = 70;
  localparam int LINE_W     = 7;
  localparam int HDR_DIGITS = 5;
  localparam int HDR_BCD_W  = 4 * HDR_DIGITS;
  localparam int CONV_CNT_W = $clog2(DIM_BITS);
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_P     = 8'h50;

  typedef struct packed {
    logic             hdr;
    logic             row_end;
    logic             frame_end;
    logic [2:0][11:0] bcd;
    logic [2:0][1:0]  ndig;
  } item_t;

  function automatic logic [7:0] clamp_level(input logic [LEVEL_W-1:0] raw);
    logic [7:0] r;
    if (raw[LEVEL_W-1]) begin
      r = 8'd0;
    end else if (raw[LEVEL_W-2:8] != '0) begin
      r = 8'd255;
    end else begin
      r = raw[7:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] level_ndig(input logic [7:0] v);
    return (v > 8'd99) ? 2'd3 : ((v > 8'd9) ? 2'd2 : 2'd1);
  endfunction

  function automatic logic [11:0] level_bcd(input logic [7:0] v);
    logic [19:0] s;
    s = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (s[8+4*k +: 4] >= 4'd5) begin
          s[8+4*k +: 4] = s[8+4*k +: 4] + 4'd3;
        end
      end
      s = s << 1;
    end
    return s[19:8];
  endfunction

  function automatic logic [2:0] bcd_ndig(input logic [HDR_BCD_W-1:0] b);
    logic [2:0] n;
    n = 3'd1;
    for (int k = 1; k < HDR_DIGITS; k++) begin
      if (b[4*k +: 4] != 4'd0) begin
        n = 3'(k + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] hdr_head_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_P;
      2'd1:    c = CH_THREE;
      default: c = CH_NL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hdr_tail_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd1:    c = CH_TWO;
      3'd2:    c = CH_FIVE;
      3'd3:    c = CH_FIVE;
      default: c = CH_NL;
    endcase
    return c;
  endfunction

endpackage

/* rtl/ppe_if.sv */
// Valid/ready channels of the PPM text encoder: pixel input and text output.
// Depends on ppe_pkg.
interface ppe_pixel_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppe_pkg::LEVEL_W-1:0] red_level;
  logic signed [ppe_pkg::LEVEL_W-1:0] green_level;
  logic signed [ppe_pkg::LEVEL_W-1:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface

interface ppe_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_of_run;
  logic       frame_done;

  modport source (output valid, text_byte, last_of_run, frame_done, input ready);
  modport sink   (input valid, text_byte, last_of_run, frame_done, output ready);
endinterface

/* rtl/ppe_front.sv */
// Front end: accepts pixels, clamps and converts components, tracks position.
// Depends on ppe_pkg and ppe_if.
module ppe_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ppe_pixel_if.sink                     pixel_i,
  input  logic [ppe_pkg::DIM_BITS-1:0]  width_i,
  input  logic [ppe_pkg::DIM_BITS-1:0]  height_i,
  input  logic                          full_i,
  output logic                          push_valid_o,
  output ppe_pkg::item_t                push_item_o
);

  logic [ppe_pkg::DIM_BITS-1:0] col_q, col_d;
  logic [ppe_pkg::DIM_BITS-1:0] row_q, row_d;
  logic [ppe_pkg::DIM_BITS:0]   col_inc;
  logic [ppe_pkg::DIM_BITS:0]   row_inc;
  logic                         col_last;
  logic                         row_last;
  logic                         accept;
  logic [2:0][ppe_pkg::LEVEL_W-1:0] raw;
  logic [2:0][7:0]              lvl;

  assign pixel_i.ready = !full_i;
  assign accept        = pixel_i.valid && !full_i;
  assign push_valid_o  = accept;

  assign col_inc  = {1'b0, col_q} + {{ppe_pkg::DIM_BITS{1'b0}}, 1'b1};
  assign row_inc  = {1'b0, row_q} + {{ppe_pkg::DIM_BITS{1'b0}}, 1'b1};
  assign col_last = col_inc >= {1'b0, width_i};
  assign row_last = row_inc >= {1'b0, height_i};

  assign raw = {pixel_i.blue_level, pixel_i.green_level, pixel_i.red_level};

  always_comb begin
    push_item_o           = '0;
    push_item_o.hdr       = (col_q == '0) && (row_q == '0);
    push_item_o.row_end   = col_last;
    push_item_o.frame_end = col_last && row_last;
    for (int k = 0; k < 3; k++) begin
      lvl[k]                = ppe_pkg::clamp_level(raw[k]);
      push_item_o.bcd[k]    = ppe_pkg::level_bcd(lvl[k]);
      push_item_o.ndig[k]   = ppe_pkg::level_ndig(lvl[k]);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_inc[ppe_pkg::DIM_BITS-1:0];
      end else begin
        col_d = col_inc[ppe_pkg::DIM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* rtl/ppe_queue.sv */
// Short item queue between front and back end.
// Depends on ppe_pkg and the assertion macro header.
`include "ppm_ascii_pixel_encoder_top_defines.svh"

module ppe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  ppe_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ppe_pkg::item_t head_o
);

  ppe_pkg::item_t            mem_q [ppe_pkg::QDEPTH];
  logic [ppe_pkg::QAW-1:0]   wptr_q, rptr_q;
  logic [ppe_pkg::QAW:0]     cnt_q, cnt_d;

  assign full_o  = cnt_q == (ppe_pkg::QAW + 1)'(ppe_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_valid_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_valid_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_valid_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  `PPE_ASSERT(a_q_no_pop_empty, pop_i |-> !empty_o, "queue popped while empty")
  `PPE_ASSERT_NEXT(a_q_push_fill, push_valid_i && !pop_i, cnt_q != '0, "push lost")

endmodule

/* rtl/ppe_back.sv */
// Back end: header, digit, wrap and row-end sequencer with output register.
// Depends on ppe_pkg, ppe_if and the assertion macro header.
`include "ppm_ascii_pixel_encoder_top_defines.svh"

module ppe_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppe_pkg::item_t                head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  logic [ppe_pkg::DIM_BITS-1:0]  width_i,
  input  logic [ppe_pkg::DIM_BITS-1:0]  height_i,
  ppe_text_if.source                    text_o
);

  localparam logic [3:0] S_DIG  = 4'd0;
  localparam logic [3:0] S_SP   = 4'd1;
  localparam logic [3:0] S_EOL  = 4'd2;
  localparam logic [3:0] S_CONV = 4'd3;
  localparam logic [3:0] S_HP   = 4'd4;
  localparam logic [3:0] S_HW   = 4'd5;
  localparam logic [3:0] S_HSP  = 4'd6;
  localparam logic [3:0] S_HH   = 4'd7;
  localparam logic [3:0] S_HT   = 4'd8;

  localparam int BW = ppe_pkg::HDR_BCD_W;
  localparam int DB = ppe_pkg::DIM_BITS;

  function automatic logic [BW-1:0] dd_step(input logic [BW-1:0] b, input logic bit_in);
    logic [BW-1:0] s;
    s = b;
    for (int k = 0; k < ppe_pkg::HDR_DIGITS; k++) begin
      if (s[4*k +: 4] >= 4'd5) begin
        s[4*k +: 4] = s[4*k +: 4] + 4'd3;
      end
    end
    return {s[BW-2:0], bit_in};
  endfunction

  logic [3:0]                       state_q, state_d;
  logic [1:0]                       comp_q, comp_d;
  logic [1:0]                       didx_q, didx_d;
  logic [2:0]                       hidx_q, hidx_d;
  logic [ppe_pkg::LINE_W-1:0]       line_q, line_d;
  logic                             hdr_done_q, hdr_done_d;
  logic [ppe_pkg::CONV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [DB-1:0]                    wsh_q, wsh_d, hsh_q, hsh_d;
  logic [BW-1:0]                    wbcd_q, wbcd_d, hbcd_q, hbcd_d;
  logic                             out_valid_q;
  logic [7:0]                       byte_q;
  logic                             last_q, fdone_q;

  logic                             adv;
  logic                             emit;
  logic [7:0]                       byte_n;
  logic                             last_n, fdone_n;
  logic [11:0]                      cur_bcd, comp_sh;
  logic [1:0]                       cur_nd, cpos;
  logic [3:0]                       cdig;
  logic                             wrap;
  logic [2:0]                       wn, hn, wpos, hpos;
  logic [BW-1:0]                    wsh_bcd, hsh_bcd;

  assign adv     = !out_valid_q || text_o.ready;
  assign cur_bcd = head_i.bcd[comp_q];
  assign cur_nd  = head_i.ndig[comp_q];
  assign cpos    = cur_nd - 2'd1 - didx_q;
  assign comp_sh = cur_bcd >> {cpos, 2'b00};
  assign cdig    = comp_sh[3:0];
  assign wrap    = ({1'b0, line_q} + {6'd0, cur_nd}) > 8'(ppe_pkg::LINE_LIMIT);
  assign wn      = ppe_pkg::bcd_ndig(wbcd_q);
  assign hn      = ppe_pkg::bcd_ndig(hbcd_q);
  assign wpos    = wn - 3'd1 - hidx_q;
  assign hpos    = hn - 3'd1 - hidx_q;
  assign wsh_bcd = wbcd_q >> {wpos, 2'b00};
  assign hsh_bcd = hbcd_q >> {hpos, 2'b00};

  always_comb begin
    state_d    = state_q;
    comp_d     = comp_q;
    didx_d     = didx_q;
    hidx_d     = hidx_q;
    line_d     = line_q;
    hdr_done_d = hdr_done_q;
    cnt_d      = cnt_q;
    wsh_d      = wsh_q;
    hsh_d      = hsh_q;
    wbcd_d     = wbcd_q;
    hbcd_d     = hbcd_q;
    emit       = 1'b0;
    byte_n     = ppe_pkg::CH_NL;
    last_n     = 1'b0;
    fdone_n    = 1'b0;
    pop_o      = 1'b0;
    case (state_q)
      S_DIG: begin
        if (!empty_i) begin
          if (head_i.hdr && !hdr_done_q) begin
            state_d = S_CONV;
            cnt_d   = '0;
            hidx_d  = '0;
            wsh_d   = width_i;
            hsh_d   = height_i;
            wbcd_d  = '0;
            hbcd_d  = '0;
          end else if (adv) begin
            emit = 1'b1;
            if (didx_q == 2'd0 && wrap) begin
              byte_n = ppe_pkg::CH_NL;
              line_d = '0;
            end else begin
              byte_n = ppe_pkg::CH_ZERO | {4'd0, cdig};
              if (didx_q == cur_nd - 2'd1) begin
                state_d = S_SP;
                didx_d  = '0;
              end else begin
                didx_d = didx_q + 2'd1;
              end
            end
          end
        end
      end
      S_SP: begin
        if (adv) begin
          emit   = 1'b1;
          byte_n = ppe_pkg::CH_SP;
          line_d = line_q + {5'd0, cur_nd} + 7'd1;
          if (comp_q == 2'd2) begin
            if (head_i.row_end) begin
              state_d = S_EOL;
            end else begin
              last_n     = 1'b1;
              pop_o      = 1'b1;
              comp_d     = '0;
              hdr_done_d = 1'b0;
              state_d    = S_DIG;
            end
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = S_DIG;
          end
        end
      end
      S_EOL: begin
        if (adv) begin
          emit       = 1'b1;
          byte_n     = ppe_pkg::CH_NL;
          line_d     = '0;
          last_n     = 1'b1;
          fdone_n    = head_i.frame_end;
          pop_o      = 1'b1;
          comp_d     = '0;
          hdr_done_d = 1'b0;
          state_d    = S_DIG;
        end
      end
      S_CONV: begin
        wbcd_d = dd_step(wbcd_q, wsh_q[DB-1]);
        hbcd_d = dd_step(hbcd_q, hsh_q[DB-1]);
        wsh_d  = wsh_q << 1;
        hsh_d  = hsh_q << 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == ppe_pkg::CONV_CNT_W'(DB - 1)) begin
          state_d = S_HP;
        end
      end
      S_HP: begin
        if (adv) begin
          emit   = 1'b1;
          byte_n = ppe_pkg::hdr_head_char(hidx_q[1:0]);
          if (hidx_q == 3'd2) begin
            hidx_d  = '0;
            state_d = S_HW;
          end else begin
            hidx_d = hidx_q + 3'd1;
          end
        end
      end
      S_HW: begin
        if (adv) begin
          emit   = 1'b1;
          byte_n = ppe_pkg::CH_ZERO | {4'd0, wsh_bcd[3:0]};
          if (hidx_q == wn - 3'd1) begin
            hidx_d  = '0;
            state_d = S_HSP;
          end else begin
            hidx_d = hidx_q + 3'd1;
          end
        end
      end
      S_HSP: begin
        if (adv) begin
          emit    = 1'b1;
          byte_n  = ppe_pkg::CH_SP;
          state_d = S_HH;
        end
      end
      S_HH: begin
        if (adv) begin
          emit   = 1'b1;
          byte_n = ppe_pkg::CH_ZERO | {4'd0, hsh_bcd[3:0]};
          if (hidx_q == hn - 3'd1) begin
            hidx_d  = '0;
            state_d = S_HT;
          end else begin
            hidx_d = hidx_q + 3'd1;
          end
        end
      end
      S_HT: begin
        if (adv) begin
          emit   = 1'b1;
          byte_n = ppe_pkg::hdr_tail_char(hidx_q);
          if (hidx_q == 3'd4) begin
            hidx_d     = '0;
            hdr_done_d = 1'b1;
            state_d    = S_DIG;
          end else begin
            hidx_d = hidx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_DIG;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_DIG;
      comp_q      <= '0;
      didx_q      <= '0;
      hidx_q      <= '0;
      line_q      <= '0;
      hdr_done_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      comp_q     <= comp_d;
      didx_q     <= didx_d;
      hidx_q     <= hidx_d;
      line_q     <= line_d;
      hdr_done_q <= hdr_done_d;
      cnt_q      <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (text_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wsh_q  <= wsh_d;
    hsh_q  <= hsh_d;
    wbcd_q <= wbcd_d;
    hbcd_q <= hbcd_d;
    if (emit) begin
      byte_q  <= byte_n;
      last_q  <= last_n;
      fdone_q <= fdone_n;
    end
  end

  assign text_o.valid       = out_valid_q;
  assign text_o.text_byte   = byte_q;
  assign text_o.last_of_run = last_q;
  assign text_o.frame_done  = fdone_q;

  `PPE_ASSERT(a_bk_fdone_last, text_o.valid && text_o.frame_done |-> text_o.last_of_run,
              "frame_done without last_of_run")
  `PPE_ASSERT(a_bk_conv_no_pop, state_q == S_CONV |-> !pop_o && !emit,
              "output during conversion")

endmodule

/* rtl/ppm_ascii_pixel_encoder_top.sv */
// Top level of the PPM P3 text encoder: config registers, front, queue, back.
// Depends on ppe_pkg, ppe_if, ppe_front, ppe_queue and ppe_back.
//
//   channel   dir  handshake          payload
//   pixel_i   in   valid/ready        red_level, green_level, blue_level (s16 Q16.0)
//   text_o    out  valid/ready        text_byte, last_of_run, frame_done
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (width, height)
//
// One text byte leaves per cycle while text_o is ready and the queue is not empty, but
// none during size conversion. A pixel yields up to three digits and a space per
// component, plus a newline at row end and one before digits past the 70-column limit.
// A frame's first pixel has the size converted to decimal, then up to 19 header bytes.
// A four-entry queue lets the front take pixels while the back end or text_o stalls.
// Reset is asynchronous; both dimensions reset to 1 and position counters to zero.
module ppm_ascii_pixel_encoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ppe_pixel_if.sink                       pixel_i,
  ppe_text_if.source                      text_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [ppe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [ppe_pkg::DIM_BITS-1:0] width_q;
  logic [ppe_pkg::DIM_BITS-1:0] height_q;
  logic                         push_valid;
  ppe_pkg::item_t               push_item;
  ppe_pkg::item_t               head;
  logic                         full;
  logic                         empty;
  logic                         pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ppe_pkg::DIM_BITS'(1);
      height_q <= ppe_pkg::DIM_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppe_pkg::REG_WIDTH:  width_q  <= cfg_data_i[ppe_pkg::DIM_BITS-1:0];
        ppe_pkg::REG_HEIGHT: height_q <= cfg_data_i[ppe_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  ppe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_i      (pixel_i),
    .width_i      (width_q),
    .height_i     (height_q),
    .full_i       (full),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  ppe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .head_o       (head)
  );

  ppe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .width_i  (width_q),
    .height_i (height_q),
    .text_o   (text_o)
  );

endmodule
